/* rtl/skht_pkg.sv */
// ----------------------------------------------------------------------------
// skht_pkg
// Shared constants, request/status codes and types for the string-key hash
// table with quadratic probing.
// ----------------------------------------------------------------------------
package skht_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 101;
    localparam int MAX_PROBES  = 20;
    localparam int KEY_BYTES   = 14;

    // Hash and probe constants
    localparam int HASH_MUL  = 19;
    localparam int PROBE_LIN = 23;

    // Fixed field widths
    localparam int FIELD_W  = 56;
    localparam int KEY_W    = 2 * FIELD_W;
    localparam int KEY_SLOTS_MAX = KEY_W / 8;
    localparam int SLOT_W   = 7;
    localparam int TOTAL_W  = 7;
    localparam int STATUS_W = 3;
    localparam int REQ_W    = 2;

    // Derived widths
    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam int CNT_W   = $clog2(MAX_PROBES + 1);
    localparam int POS_W   = $clog2(KEY_BYTES + 1);
    localparam int SUM_MAX = 255 * KEY_BYTES * (KEY_BYTES + 1) / 2;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int PROD_W  = $clog2(SUM_MAX * HASH_MUL + 1);

    // Reciprocal for the mod-TABLE_SLOTS reduction (floor, fixed up later)
    localparam int      RECIP_SH = PROD_W;
    localparam longint  RECIP    = (longint'(1) << RECIP_SH) / TABLE_SLOTS;
    localparam int      RECIP_W  = $clog2(RECIP + 1);

    // Step between probe j and j+1 is 2j + 1 + PROBE_LIN; this is j = 0
    localparam int DELTA0 = (1 + PROBE_LIN) % TABLE_SLOTS;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEL   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_READ     = 3'd6;

    // Hash unit response
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] home;
    } t_hash_rsp;

endpackage

/* rtl/skht_key_ram.sv */
// ----------------------------------------------------------------------------
// skht_key_ram
// Simple dual-port key store: one write port, one read port, registered
// read data. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module skht_key_ram #(
    parameter int DEPTH = 101,
    parameter int WIDTH = 112,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/skht_hash.sv */
// ----------------------------------------------------------------------------
// skht_hash
// Home slot unit: accumulates byte * (position + 1) one byte per cycle,
// then scales by the hash multiplier and reduces mod TABLE_SLOTS through a
// reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module skht_hash (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [skht_pkg::KEY_W-1:0] i_key,
    output skht_pkg::t_hash_rsp       o_rsp
);

    localparam int IDX_W   = skht_pkg::IDX_W;
    localparam int SUM_W   = skht_pkg::SUM_W;
    localparam int PROD_W  = skht_pkg::PROD_W;
    localparam int POS_W   = skht_pkg::POS_W;
    localparam int RECIP_W = skht_pkg::RECIP_W;
    localparam int KEY_W   = skht_pkg::KEY_W;

    localparam logic [PROD_W-1:0]  MUL_P   = PROD_W'(skht_pkg::HASH_MUL);
    localparam logic [PROD_W-1:0]  SLOTS_P = PROD_W'(skht_pkg::TABLE_SLOTS);
    localparam logic [IDX_W:0]     SLOTS_R = (IDX_W + 1)'(skht_pkg::TABLE_SLOTS);
    localparam logic [RECIP_W-1:0] RECIP_P = RECIP_W'(skht_pkg::RECIP);
    localparam logic [POS_W-1:0]   LAST_POS = POS_W'(skht_pkg::KEY_BYTES - 1);

    // Phase codes
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SUM  = 3'd1;
    localparam logic [2:0] PH_MUL  = 3'd2;
    localparam logic [2:0] PH_QUOT = 3'd3;
    localparam logic [2:0] PH_REM  = 3'd4;
    localparam logic [2:0] PH_FIX  = 3'd5;

    logic [2:0]                r_phase, n_phase;
    logic [KEY_W-1:0]          r_shift, n_shift;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic [SUM_W-1:0]          r_sum, n_sum;
    logic [PROD_W-1:0]         r_prod, n_prod;
    logic [RECIP_W-1:0]        r_quot, n_quot;
    logic [IDX_W:0]            r_rem, n_rem;
    logic                      r_done, n_done;
    logic [IDX_W-1:0]          r_home, n_home;

    logic [SUM_W-1:0]          term;
    logic [PROD_W+RECIP_W-1:0] prod_m;
    logic [PROD_W-1:0]         rem_full;

    // Datapath pieces
    assign term     = SUM_W'(r_shift[7:0]) * SUM_W'(r_pos + POS_W'(1));
    assign prod_m   = (PROD_W + RECIP_W)'(r_prod) * (PROD_W + RECIP_W)'(RECIP_P);
    assign rem_full = r_prod - PROD_W'(r_quot) * SLOTS_P;

    // Sequencer
    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_prod  = r_prod;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_done  = 1'b0;
        n_home  = r_home;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_shift = i_key;
                    n_pos   = '0;
                    n_sum   = '0;
                    n_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                n_sum   = r_sum + term;
                n_shift = r_shift >> 8;
                n_pos   = r_pos + POS_W'(1);
                if (r_pos == LAST_POS) begin
                    n_phase = PH_MUL;
                end
            end
            PH_MUL: begin
                n_prod  = PROD_W'(r_sum) * MUL_P;
                n_phase = PH_QUOT;
            end
            PH_QUOT: begin
                n_quot  = prod_m[PROD_W+RECIP_W-1:skht_pkg::RECIP_SH];
                n_phase = PH_REM;
            end
            PH_REM: begin
                n_rem   = rem_full[IDX_W:0];
                n_phase = PH_FIX;
            end
            PH_FIX: begin
                n_home  = (r_rem >= SLOTS_R) ? IDX_W'(r_rem - SLOTS_R) : IDX_W'(r_rem);
                n_done  = 1'b1;
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_shift <= n_shift;
        r_pos   <= n_pos;
        r_sum   <= n_sum;
        r_prod  <= n_prod;
        r_quot  <= n_quot;
        r_rem   <= n_rem;
        r_home  <= n_home;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.home = r_home;

endmodule

/* rtl/string_key_hash_table_quadratic_probe_unit.sv */
// ----------------------------------------------------------------------------
// string_key_hash_table_quadratic_probe_unit
// Open-addressed table of string keys with quadratic probing.
//
// Add and delete first build the home slot one key byte per cycle,
// followed by scaling and the mod reduction, then the 20 probe slots are
// read one per cycle through the key memory's single read port while each
// returned key is compared, and the result is committed once the output
// register is free. An add finds a duplicate and the first free probe in
// that same pass. One request is worked on at a time; the next request is
// taken while a finished result still waits in the output register. Keys
// end at their first zero byte. Occupancy is kept in one flag per slot, so
// clear empties every slot together and no clearing pass follows reset.
// ----------------------------------------------------------------------------
module string_key_hash_table_quadratic_probe_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [skht_pkg::REQ_W-1:0]    i_req_type,
    input  logic [skht_pkg::FIELD_W-1:0]  i_key_lo,
    input  logic [skht_pkg::FIELD_W-1:0]  i_key_hi,
    input  logic [skht_pkg::SLOT_W-1:0]   i_slot_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [skht_pkg::STATUS_W-1:0] o_status,
    output logic [skht_pkg::SLOT_W-1:0]   o_slot,
    output logic [skht_pkg::TOTAL_W-1:0]  o_entry_total,
    output logic                          o_occupied,
    output logic [skht_pkg::FIELD_W-1:0]  o_out_key_lo,
    output logic [skht_pkg::FIELD_W-1:0]  o_out_key_hi
);

    localparam int TABLE_SLOTS = skht_pkg::TABLE_SLOTS;
    localparam int IDX_W       = skht_pkg::IDX_W;
    localparam int CNT_W       = skht_pkg::CNT_W;
    localparam int KEY_W       = skht_pkg::KEY_W;
    localparam int FIELD_W     = skht_pkg::FIELD_W;
    localparam int SLOT_W      = skht_pkg::SLOT_W;
    localparam int TOTAL_W     = skht_pkg::TOTAL_W;
    localparam int STATUS_W    = skht_pkg::STATUS_W;
    localparam int REQ_W       = skht_pkg::REQ_W;

    localparam logic [IDX_W:0]   SLOTS_E    = (IDX_W + 1)'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] DELTA0_P   = IDX_W'(skht_pkg::DELTA0);
    localparam logic [CNT_W-1:0] PROBES_P   = CNT_W'(skht_pkg::MAX_PROBES);

    // State codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HASH   = 3'd1;
    localparam logic [2:0] S_PROBE  = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [REQ_W-1:0]       r_req, n_req;
    logic [KEY_W-1:0]       r_key, n_key;
    logic [SLOT_W-1:0]      r_index, n_index;
    logic [IDX_W-1:0]       r_probe, n_probe;
    logic [IDX_W-1:0]       r_delta, n_delta;
    logic [CNT_W-1:0]       r_pcnt, n_pcnt;
    logic                   r_cmp_act, n_cmp_act;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]       r_cmp_slot, n_cmp_slot;
    logic                   r_found, n_found;
    logic [IDX_W-1:0]       r_match_slot, n_match_slot;
    logic                   r_free_found, n_free_found;
    logic [IDX_W-1:0]       r_free_slot, n_free_slot;
    logic [TABLE_SLOTS-1:0] r_slot_valid, n_slot_valid;
    logic [TOTAL_W-1:0]     r_count, n_count;

    logic                   r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]    r_o_status, n_o_status;
    logic [SLOT_W-1:0]      r_o_slot, n_o_slot;
    logic [TOTAL_W-1:0]     r_o_total, n_o_total;
    logic                   r_o_occ, n_o_occ;
    logic [KEY_W-1:0]       r_o_key, n_o_key;

    logic [KEY_W-1:0]       key_raw;
    logic [KEY_W-1:0]       key_norm;
    logic                   norm_live;
    logic                   out_free;
    logic                   in_idx_ok;
    logic                   idx_ok;
    logic [IDX_W:0]         probe_sum;
    logic [IDX_W:0]         delta_sum;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [KEY_W-1:0]       ram_rd_data;

    logic                   hash_start;
    skht_pkg::t_hash_rsp    hash_rsp;

    // Key normalization: bytes after the first zero byte read as zero
    assign key_raw = {i_key_hi, i_key_lo};
    always_comb begin
        norm_live = 1'b1;
        key_norm  = '0;
        for (int i = 0; i < skht_pkg::KEY_SLOTS_MAX; i++) begin
            norm_live = norm_live && (key_raw[8*i +: 8] != 8'd0) && (i < skht_pkg::KEY_BYTES);
            key_norm[8*i +: 8] = norm_live ? key_raw[8*i +: 8] : 8'd0;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_idx_ok  = (32'(i_slot_index) < TABLE_SLOTS);
    assign idx_ok     = (32'(r_index) < TABLE_SLOTS);
    assign hash_start = i_in_valid && (r_state == S_IDLE)
                        && ((i_req_type == skht_pkg::REQ_ADD) || (i_req_type == skht_pkg::REQ_DEL));

    // Next probe slot and next step, each reduced with one subtract
    assign probe_sum = {1'b0, r_probe} + {1'b0, r_delta};
    assign delta_sum = {1'b0, r_delta} + (IDX_W + 1)'(2);

    // Home slot unit
    skht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (key_norm),
        .o_rsp   (hash_rsp)
    );

    // Key store
    skht_key_ram #(
        .DEPTH (TABLE_SLOTS),
        .WIDTH (KEY_W)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (r_key),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Control and commit
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_key        = r_key;
        n_index      = r_index;
        n_probe      = r_probe;
        n_delta      = r_delta;
        n_pcnt       = r_pcnt;
        n_cmp_act    = r_cmp_act;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_slot   = r_cmp_slot;
        n_found      = r_found;
        n_match_slot = r_match_slot;
        n_free_found = r_free_found;
        n_free_slot  = r_free_slot;
        n_slot_valid = r_slot_valid;
        n_count      = r_count;
        n_out_valid  = r_out_valid && i_out_stall;
        n_o_status   = r_o_status;
        n_o_slot     = r_o_slot;
        n_o_total    = r_o_total;
        n_o_occ      = r_o_occ;
        n_o_key      = r_o_key;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_free_slot;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_probe;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_req_type;
                    n_key   = key_norm;
                    n_index = i_slot_index;
                    case (i_req_type)
                        skht_pkg::REQ_ADD,
                        skht_pkg::REQ_DEL: begin
                            n_state = S_HASH;
                        end
                        skht_pkg::REQ_READ: begin
                            ram_rd_en   = in_idx_ok;
                            ram_rd_addr = IDX_W'(i_slot_index);
                            n_state     = S_READ;
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end

            S_HASH: begin
                if (hash_rsp.done) begin
                    n_probe      = hash_rsp.home;
                    n_delta      = DELTA0_P;
                    n_pcnt       = '0;
                    n_cmp_act    = 1'b0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_state      = S_PROBE;
                end
            end

            S_PROBE: begin
                // Issue one probe read per cycle; note the first free probe
                if (r_pcnt != PROBES_P) begin
                    ram_rd_en  = 1'b1;
                    n_cmp_act  = 1'b1;
                    n_cmp_slot = r_probe;
                    n_cmp_vld  = r_slot_valid[r_probe];
                    if (!r_slot_valid[r_probe] && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_slot  = r_probe;
                    end
                    n_probe = (probe_sum >= SLOTS_E) ? IDX_W'(probe_sum - SLOTS_E)
                                                     : IDX_W'(probe_sum);
                    n_delta = (delta_sum >= SLOTS_E) ? IDX_W'(delta_sum - SLOTS_E)
                                                     : IDX_W'(delta_sum);
                    n_pcnt  = r_pcnt + CNT_W'(1);
                end else begin
                    n_cmp_act = 1'b0;
                    n_state   = S_RESULT;
                end
                // Compare the key read in the previous cycle
                if (r_cmp_act && r_cmp_vld && !r_found && (ram_rd_data == r_key)) begin
                    n_found      = 1'b1;
                    n_match_slot = r_cmp_slot;
                end
            end

            S_READ: begin
                n_state = S_RESULT;
            end

            S_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_o_slot    = '0;
                    n_o_occ     = 1'b0;
                    n_o_key     = '0;
                    case (r_req)
                        skht_pkg::REQ_ADD: begin
                            if (r_found) begin
                                n_o_status = skht_pkg::ST_PRESENT;
                                n_o_slot   = SLOT_W'(r_match_slot);
                            end else if (r_free_found) begin
                                ram_wr_en                 = 1'b1;
                                n_slot_valid[r_free_slot] = 1'b1;
                                n_count                   = r_count + TOTAL_W'(1);
                                n_o_status                = skht_pkg::ST_ADDED;
                                n_o_slot                  = SLOT_W'(r_free_slot);
                            end else begin
                                n_o_status = skht_pkg::ST_NO_FREE;
                            end
                        end
                        skht_pkg::REQ_DEL: begin
                            if (r_found) begin
                                n_slot_valid[r_match_slot] = 1'b0;
                                if (r_count != '0) begin
                                    n_count = r_count - TOTAL_W'(1);
                                end
                                n_o_status = skht_pkg::ST_DELETED;
                                n_o_slot   = SLOT_W'(r_match_slot);
                            end else begin
                                n_o_status = skht_pkg::ST_NOTFOUND;
                            end
                        end
                        skht_pkg::REQ_CLEAR: begin
                            n_slot_valid = '0;
                            n_count      = '0;
                            n_o_status   = skht_pkg::ST_CLEARED;
                        end
                        default: begin
                            n_o_status = skht_pkg::ST_READ;
                            if (idx_ok) begin
                                n_o_slot = r_index;
                                if (r_slot_valid[IDX_W'(r_index)]) begin
                                    n_o_occ = 1'b1;
                                    n_o_key = ram_rd_data;
                                end
                            end
                        end
                    endcase
                    n_o_total = n_count;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cmp_act    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_slot_valid <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_pcnt       <= '0;
        end else begin
            r_state      <= n_state;
            r_cmp_act    <= n_cmp_act;
            r_found      <= n_found;
            r_free_found <= n_free_found;
            r_slot_valid <= n_slot_valid;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_pcnt       <= n_pcnt;
        end
        r_req        <= n_req;
        r_key        <= n_key;
        r_index      <= n_index;
        r_probe      <= n_probe;
        r_delta      <= n_delta;
        r_cmp_vld    <= n_cmp_vld;
        r_cmp_slot   <= n_cmp_slot;
        r_match_slot <= n_match_slot;
        r_free_slot  <= n_free_slot;
        r_o_status   <= n_o_status;
        r_o_slot     <= n_o_slot;
        r_o_total    <= n_o_total;
        r_o_occ      <= n_o_occ;
        r_o_key      <= n_o_key;
    end

    // Output beat
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_slot        = r_o_slot;
    assign o_entry_total = r_o_total;
    assign o_occupied    = r_o_occ;
    assign o_out_key_lo  = r_o_key[FIELD_W-1:0];
    assign o_out_key_hi  = r_o_key[KEY_W-1:FIELD_W];

`ifndef ASSERT_OFF
    // Entry count tracks the occupancy flags
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_slot_valid) == 32'(r_count))
        else $error("entry count disagrees with occupancy flags");

    // Probe address stays inside the table
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (32'(r_probe) < TABLE_SLOTS))
        else $error("probe slot out of range");

    // A matched slot is still occupied when the result commits
    a_match_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RESULT) && r_found
         && ((r_req == skht_pkg::REQ_ADD) || (r_req == skht_pkg::REQ_DEL)))
        |-> r_slot_valid[r_match_slot])
        else $error("matched slot is not occupied");

    // A successful add marks its slot occupied
    a_add_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RESULT) && out_free && (r_req == skht_pkg::REQ_ADD)
         && !r_found && r_free_found)
        |=> r_slot_valid[$past(r_free_slot)])
        else $error("add did not occupy its slot");
`endif

endmodule
